FILE: sv/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg: shared definitions for the I2C slave byte sequencer
// Event, result, phase and transaction codes, the result record and the
// default sizes.
// ----------------------------------------------------------------------------
package isb_pkg;

  localparam int BUFFER_DEPTH_DEF = 32;
  localparam int BYTE_W           = 8;
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;

  // bus event codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_SHIFT = 2'd2;
  localparam logic [1:0] ACT_LOAD  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SHIFT    = 2'd0;
  localparam logic [1:0] KIND_RELEASED = 2'd1;
  localparam logic [1:0] KIND_DELIVER  = 2'd2;
  localparam logic [1:0] KIND_NOTHING  = 2'd3;

  // byte phases
  localparam logic [2:0] PH_CHECK_ADDRESS = 3'd0;
  localparam logic [2:0] PH_SEND_DATA     = 3'd1;
  localparam logic [2:0] PH_REQUEST_ACK   = 3'd2;
  localparam logic [2:0] PH_CHECK_ACK     = 3'd3;
  localparam logic [2:0] PH_RECEIVE_DATA  = 3'd4;
  localparam logic [2:0] PH_STORE_AND_ACK = 3'd5;

  // transaction states
  localparam logic [2:0] TR_BEFORE_START   = 3'd0;
  localparam logic [2:0] TR_AFTER_START    = 3'd1;
  localparam logic [2:0] TR_SELECTED       = 3'd2;
  localparam logic [2:0] TR_NOT_SELECTED   = 3'd3;
  localparam logic [2:0] TR_DATA_PROCESSED = 3'd4;

  // register word index
  localparam logic REG_OWN_ADDRESS = 1'b0;

  localparam logic [3:0] BITS_DATA = 4'd8;
  localparam logic [3:0] BITS_ACK  = 4'd1;

  localparam logic [7:0] BYTE_IDLE = 8'hff;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] shift_byte;
    logic [3:0] shift_bits;
    logic       sda_drive;
    logic [7:0] rx_byte;
    logic       rx_empty;
    logic       last;
  } res_t;

endpackage

FILE: sv/isb_ram.sv
// ----------------------------------------------------------------------------
// isb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module isb_ram #(
  parameter int WIDTH = isb_pkg::BYTE_W,
  parameter int DEPTH = isb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import isb_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/i2c_slave_byte_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_slave_byte_sequencer: byte-level I2C slave, 7-bit address
// A request is taken in ST_IDLE and decided in ST_EXEC, where its result is
//   registered once the result side is free; no new request is taken until then.
// A stop that delivers received bytes walks the receive RAM in ST_DELIVER,
//   one byte per result, through the single read port of the receive RAM.
// Reset (synchronous, rst high) clears control state, counters and the own
//   address; the byte RAMs are not cleared, the counters mark what is valid.
// ----------------------------------------------------------------------------
module i2c_slave_byte_sequencer #(
  parameter int BUFFER_DEPTH = isb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  action,
  input  logic [7:0]                  data,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [1:0]                  kind,
  output logic [7:0]                  shift_byte,
  output logic [3:0]                  shift_bits,
  output logic                        sda_drive,
  output logic [7:0]                  rx_byte,
  output logic                        rx_empty,
  output logic                        last,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [isb_pkg::APB_AW-1:0]  paddr,
  input  logic [isb_pkg::APB_DW-1:0]  pwdata,
  output logic [isb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import isb_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  // stores keep at most depth minus one bytes
  localparam logic [AW-1:0] LIMIT = AW'(BUFFER_DEPTH - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE    = 2'd0;  // waiting for a request
  localparam logic [1:0] ST_EXEC    = 2'd1;  // RAM data back, decide and emit
  localparam logic [1:0] ST_DELIVER = 2'd2;  // walk the receive RAM

  logic [1:0]    st, st_next;

  // request registers
  logic [1:0]    act_q;
  logic [7:0]    dat_q;

  // sequencer state
  logic [6:0]    own_address;
  logic [2:0]    phase, phase_next;
  logic [2:0]    trans, trans_next;
  logic          shen, shen_next;
  logic [AW-1:0] rx_count, rx_count_next;
  logic [AW-1:0] tx_length, tx_length_next;
  logic [AW-1:0] tx_pointer, tx_pointer_next;
  logic [AW-1:0] rx_idx, rx_idx_next;

  // result register
  res_t          res_q;
  res_t          res_c;
  logic          emit;
  logic          out_free;

  // RAM ports
  logic          rx_we, tx_we;
  logic [AW-1:0] rx_raddr;
  logic [7:0]    rx_rdata, tx_rdata;

  logic          accept;
  logic          go_deliver;
  logic          advance;
  logic          last_byte;

  // --------------------------------------------------------------------------
  // configuration port: one register, word index in paddr[2]
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OWN_ADDRESS) ? {{(APB_DW-7){1'b0}}, own_address}
                                                : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_OWN_ADDRESS) begin
      own_address <= pwdata[6:0];
    end
  end

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign item_stall = (st != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // --------------------------------------------------------------------------
  // byte stores. The tx RAM always reads at the pointer, which moves only when
  // a request retires, so data is current in ST_EXEC. The rx RAM is read at 0
  // until delivery, then at the next index each time a byte leaves.
  // --------------------------------------------------------------------------
  isb_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_count),
    .wdata (dat_q),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  isb_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_length),
    .wdata (dat_q),
    .raddr (tx_pointer),
    .rdata (tx_rdata)
  );

  assign last_byte = (rx_idx == rx_count - AW'(1));

  always_comb begin
    rx_raddr = '0;
    if (st == ST_DELIVER) begin
      rx_raddr = out_free ? rx_idx + AW'(1) : rx_idx;
    end
  end

  // --------------------------------------------------------------------------
  // decode of one request
  // --------------------------------------------------------------------------
  always_comb begin
    res_c           = '{kind: KIND_NOTHING, default: '0};
    phase_next      = phase;
    trans_next      = trans;
    shen_next       = shen;
    rx_count_next   = rx_count;
    tx_length_next  = tx_length;
    tx_pointer_next = tx_pointer;
    rx_idx_next     = rx_idx;
    go_deliver      = 1'b0;
    rx_we           = 1'b0;
    tx_we           = 1'b0;
    emit            = 1'b0;
    st_next         = st;

    case (st)
      ST_IDLE: begin
        if (accept) begin
          st_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (act_q)
          ACT_START: begin
            phase_next = PH_CHECK_ADDRESS;
            trans_next = TR_AFTER_START;
            shen_next  = 1'b1;
            res_c      = '{kind: KIND_SHIFT, shift_byte: BYTE_IDLE,
                           shift_bits: BITS_DATA, default: '0};
          end

          ACT_STOP: begin
            trans_next = TR_BEFORE_START;
            if (trans == TR_AFTER_START) begin
              shen_next = 1'b0;
              res_c     = '{kind: KIND_RELEASED, shift_bits: BITS_DATA, default: '0};
            end else if (trans == TR_DATA_PROCESSED) begin
              if (rx_count == '0) begin
                // empty delivery: one result
                res_c           = '{kind: KIND_DELIVER, rx_empty: 1'b1, last: 1'b1,
                                    default: '0};
                tx_length_next  = '0;
                tx_pointer_next = '0;
              end else begin
                go_deliver  = 1'b1;
                rx_idx_next = '0;
              end
            end
          end

          ACT_SHIFT: begin
            if (shen) begin
              case (phase)
                PH_CHECK_ADDRESS: begin
                  if (dat_q[7:1] == own_address) begin
                    trans_next = TR_SELECTED;
                    phase_next = dat_q[0] ? PH_SEND_DATA : PH_RECEIVE_DATA;
                    res_c      = '{kind: KIND_SHIFT, shift_bits: BITS_ACK,
                                   sda_drive: 1'b1, default: '0};
                  end else begin
                    trans_next = TR_NOT_SELECTED;
                    shen_next  = 1'b0;
                    res_c      = '{kind: KIND_RELEASED, shift_bits: BITS_DATA,
                                   default: '0};
                  end
                end
                PH_SEND_DATA, PH_CHECK_ACK: begin
                  if (phase == PH_CHECK_ACK && dat_q != 8'h00) begin
                    // master NACK ends the read
                    phase_next = PH_CHECK_ADDRESS;
                    shen_next  = 1'b0;
                    res_c      = '{kind: KIND_RELEASED, shift_bits: BITS_DATA,
                                   default: '0};
                  end else begin
                    trans_next = TR_DATA_PROCESSED;
                    phase_next = PH_REQUEST_ACK;
                    res_c      = '{kind: KIND_SHIFT, shift_bits: BITS_DATA,
                                   sda_drive: 1'b1, default: '0};
                    if (tx_pointer < tx_length) begin
                      res_c.shift_byte = tx_rdata;
                      tx_pointer_next  = tx_pointer + AW'(1);
                    end
                  end
                end
                PH_REQUEST_ACK: begin
                  phase_next = PH_CHECK_ACK;
                  res_c      = '{kind: KIND_SHIFT, shift_bits: BITS_ACK, default: '0};
                end
                PH_RECEIVE_DATA: begin
                  trans_next = TR_DATA_PROCESSED;
                  phase_next = PH_STORE_AND_ACK;
                  res_c      = '{kind: KIND_SHIFT, shift_bits: BITS_DATA, default: '0};
                end
                PH_STORE_AND_ACK: begin
                  phase_next = PH_RECEIVE_DATA;
                  // full store: byte dropped, still acked
                  if (rx_count < LIMIT) begin
                    rx_we         = out_free;
                    rx_count_next = rx_count + AW'(1);
                  end
                  res_c = '{kind: KIND_SHIFT, shift_bits: BITS_ACK,
                            sda_drive: 1'b1, default: '0};
                end
                default: begin
                  phase_next = PH_CHECK_ADDRESS;
                  shen_next  = 1'b0;
                  res_c      = '{kind: KIND_RELEASED, shift_bits: BITS_DATA,
                                 default: '0};
                end
              endcase
            end
          end

          ACT_LOAD: begin
            if (tx_length < LIMIT) begin
              tx_we          = out_free;
              tx_length_next = tx_length + AW'(1);
            end
          end

          default: begin
          end
        endcase

        if (go_deliver) begin
          st_next = ST_DELIVER;
        end else if (out_free) begin
          emit    = 1'b1;
          st_next = ST_IDLE;
        end
      end

      ST_DELIVER: begin
        res_c = '{kind: KIND_DELIVER, rx_byte: rx_rdata, last: last_byte, default: '0};
        if (out_free) begin
          emit        = 1'b1;
          rx_idx_next = rx_idx + AW'(1);
          if (last_byte) begin
            rx_count_next   = '0;
            tx_length_next  = '0;
            tx_pointer_next = '0;
            st_next         = ST_IDLE;
          end
        end
      end

      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  // state moves only when the request retires or delivery starts/advances
  assign advance = (st == ST_EXEC && (out_free || go_deliver)) ||
                   (st == ST_DELIVER && out_free);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      phase        <= PH_CHECK_ADDRESS;
      trans        <= TR_BEFORE_START;
      shen         <= 1'b0;
      rx_count     <= '0;
      tx_length    <= '0;
      tx_pointer   <= '0;
      rx_idx       <= '0;
      result_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (advance) begin
        phase      <= phase_next;
        trans      <= trans_next;
        shen       <= shen_next;
        rx_count   <= rx_count_next;
        tx_length  <= tx_length_next;
        tx_pointer <= tx_pointer_next;
        rx_idx     <= rx_idx_next;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q <= action;
      dat_q <= data;
    end
    if (emit) begin
      res_q <= res_c;
    end
  end

  assign kind       = res_q.kind;
  assign shift_byte = res_q.shift_byte;
  assign shift_bits = res_q.shift_bits;
  assign sda_drive  = res_q.sda_drive;
  assign rx_byte    = res_q.rx_byte;
  assign rx_empty   = res_q.rx_empty;
  assign last       = res_q.last;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> st == ST_EXEC)
    else $error("request not followed by execute cycle");

  a_deliver_idx: assert property (@(posedge clk) disable iff (rst)
    st == ST_DELIVER |-> rx_idx < rx_count)
    else $error("delivery index past receive count");

  a_tx_ptr: assert property (@(posedge clk) disable iff (rst)
    tx_pointer <= tx_length)
    else $error("transmit pointer past transmit length");

  a_deliver_kind: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DELIVER && emit) |=> result_valid && kind == KIND_DELIVER)
    else $error("delivery result has wrong kind");

endmodule
